### hw/rtl/fsplit_pkg.sv
// Shared constants and types for the factor split unit.
package fsplit_pkg;

  localparam int unsigned DEF_VALUE_BITS = 31;
  localparam int unsigned DEF_MAX_PRIMES = 32;

  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned FIRST_W   = 14;
  localparam int unsigned DIM_LIMIT = 16384;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd8192;
  localparam logic [FIRST_W-1:0] FIRST_MAX   = 14'h3FFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIAL,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FINAL_DIV,
    ST_FINAL_WAIT
  } fsm_state_e;

endpackage

### hw/rtl/fsplit_ram.sv
// Generic single write port RAM with registered read.
module fsplit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fsplit_div.sv
// Restoring divider, one quotient bit per cycle.
module fsplit_div #(
  parameter int unsigned WIDTH = fsplit_pkg::DEF_VALUE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned CW = $clog2(WIDTH);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[WIDTH-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(WIDTH - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### hw/rtl/factor_split_two_dims_unit.sv
// Top level: trial division factoriser that splits a value into two factors.
//
//   port group        direction  handshake            payload
//   request           in         start / busy         value_to_split_i
//   result            out        done_o (one cycle)   first_factor_o, second_factor_o,
//                                                     too_large_o
//   limit register    in         cfg_we_i             cfg_wdata_i
//
// Each trial divisor costs one pass of the shared divider.
// A large prime input needs about sqrt(value) / 2 trials.
// busy is high from the accepting edge and falls in the cycle the result strobe shows.
// Reset clears the sequencer and sets the limit to 8192; the prime store has no reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
module factor_split_two_dims_unit #(
  parameter int unsigned VALUE_BITS = fsplit_pkg::DEF_VALUE_BITS,
  parameter int unsigned MAX_PRIMES = fsplit_pkg::DEF_MAX_PRIMES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [VALUE_BITS-1:0]           value_to_split_i,
  input  logic                            cfg_we_i,
  input  logic [fsplit_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  output logic                            done_o,
  output logic [fsplit_pkg::FIRST_W-1:0]  first_factor_o,
  output logic [VALUE_BITS-1:0]           second_factor_o,
  output logic                            too_large_o
);

  localparam int unsigned LW     = fsplit_pkg::LIMIT_W;
  localparam int unsigned FW     = fsplit_pkg::FIRST_W;
  localparam int unsigned PW     = 2 * LW;
  localparam int unsigned CMP_W  = (VALUE_BITS > 16) ? VALUE_BITS : 16;
  localparam int unsigned AW     = $clog2(MAX_PRIMES);
  localparam int unsigned CNT_W  = $clog2(MAX_PRIMES + 1);

  fsplit_pkg::fsm_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] dvr_q, dvr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [CNT_W-1:0]      k_m1;
  logic [LW-1:0]         first_q, first_d;
  logic [LW-1:0]         limit_q;
  logic [FW-1:0]         ff_q;
  logic [VALUE_BITS-1:0] sf_q;
  logic                  tl_q;
  logic                  done_q;
  logic                  res_load;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dvd;
  logic [VALUE_BITS-1:0] div_dvs;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;

  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_data;
  logic [VALUE_BITS-1:0] prime_rd;
  logic [CMP_W-1:0]      prime_ext;
  logic [PW-1:0]         prod;
  logic                  prime_fits;
  logic [VALUE_BITS-1:0] dvr_next;

  fsplit_div #(
    .WIDTH (VALUE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  fsplit_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_PRIMES)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wr_data),
    .raddr_i (k_m1[AW-1:0]),
    .rdata_o (prime_rd)
  );

  assign k_m1       = k_q - 1'b1;
  assign prime_ext  = CMP_W'(prime_rd);
  assign prod       = PW'(first_q) * PW'(prime_ext[LW-1:0]);
  assign prime_fits = (prime_ext < CMP_W'(limit_q)) && (prod < PW'(limit_q));
  assign dvr_next   = (dvr_q == VALUE_BITS'(2)) ? VALUE_BITS'(3) : dvr_q + VALUE_BITS'(2);

  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    rem_d     = rem_q;
    dvr_d     = dvr_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    first_d   = first_q;
    div_start = 1'b0;
    div_dvd   = rem_q;
    div_dvs   = dvr_q;
    wr_en     = 1'b0;
    wr_data   = rem_q;
    res_load  = 1'b0;
    case (state_q)
      fsplit_pkg::ST_IDLE: begin
        if (start) begin
          value_d   = value_to_split_i;
          rem_d     = value_to_split_i;
          dvr_d     = VALUE_BITS'(2);
          cnt_d     = '0;
          first_d   = LW'(1);
          div_start = 1'b1;
          div_dvd   = value_to_split_i;
          div_dvs   = VALUE_BITS'(2);
          state_d   = fsplit_pkg::ST_TRIAL;
        end
      end
      fsplit_pkg::ST_TRIAL: begin
        if (div_done) begin
          if ((div_quo < dvr_q) || (cnt_q == CNT_W'(MAX_PRIMES - 1))) begin
            k_d = cnt_q;
            if (rem_q > VALUE_BITS'(1)) begin
              wr_en = 1'b1;
              cnt_d = cnt_q + 1'b1;
              k_d   = cnt_q + 1'b1;
            end
            state_d = fsplit_pkg::ST_WALK_RD;
          end else if (div_rem == '0) begin
            wr_en     = 1'b1;
            wr_data   = dvr_q;
            cnt_d     = cnt_q + 1'b1;
            rem_d     = div_quo;
            div_start = 1'b1;
            div_dvd   = div_quo;
          end else begin
            dvr_d     = dvr_next;
            div_start = 1'b1;
            div_dvs   = dvr_next;
          end
        end
      end
      fsplit_pkg::ST_WALK_RD: begin
        if (k_q == '0) begin
          state_d = fsplit_pkg::ST_FINAL_DIV;
        end else begin
          state_d = fsplit_pkg::ST_WALK_CHK;
        end
      end
      fsplit_pkg::ST_WALK_CHK: begin
        if (prime_fits) begin
          first_d = prod[LW-1:0];
          k_d     = k_m1;
          state_d = fsplit_pkg::ST_WALK_RD;
        end else begin
          state_d = fsplit_pkg::ST_FINAL_DIV;
        end
      end
      fsplit_pkg::ST_FINAL_DIV: begin
        div_start = 1'b1;
        div_dvd   = value_q;
        div_dvs   = VALUE_BITS'(first_q);
        state_d   = fsplit_pkg::ST_FINAL_WAIT;
      end
      fsplit_pkg::ST_FINAL_WAIT: begin
        if (div_done) begin
          res_load = 1'b1;
          state_d  = fsplit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fsplit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsplit_pkg::ST_IDLE;
      limit_q <= fsplit_pkg::LIMIT_RESET;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= res_load;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rem_q   <= rem_d;
    dvr_q   <= dvr_d;
    first_q <= first_d;
    if (res_load) begin
      ff_q <= (first_q > LW'(fsplit_pkg::FIRST_MAX)) ? fsplit_pkg::FIRST_MAX
                                                     : first_q[FW-1:0];
      sf_q <= div_quo;
      tl_q <= (first_q > LW'(fsplit_pkg::DIM_LIMIT))
           || (CMP_W'(div_quo) > CMP_W'(fsplit_pkg::DIM_LIMIT));
    end
  end

  assign busy            = (state_q != fsplit_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign first_factor_o  = ff_q;
  assign second_factor_o = sf_q;
  assign too_large_o     = tl_q;

endmodule

### hw/rtl/fsplit_chk.sv
// Port level checks for the factor split unit, bound to the top level.
module fsplit_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input logic [fsplit_pkg::FIRST_W-1:0] first_factor_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_first_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (first_factor_o != '0))
    else $error("first factor is zero");

endmodule

bind factor_split_two_dims_unit fsplit_chk u_fsplit_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .first_factor_o (first_factor_o)
);

### verif/tb_factor_split_two_dims_unit.sv
// Self-checking testbench for the factor split unit: directed table, then random requests.
module tb_factor_split_two_dims_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VB = fsplit_pkg::DEF_VALUE_BITS;
  localparam int unsigned LW = fsplit_pkg::LIMIT_W;
  localparam int unsigned FW = fsplit_pkg::FIRST_W;
  localparam int unsigned PRIME_SLOTS = fsplit_pkg::DEF_MAX_PRIMES;
  localparam longint unsigned VALUE_MAX = (64'd1 << VB) - 1;

  typedef struct packed {
    logic [FW-1:0] first;
    logic [VB-1:0] second;
    logic          too_large;
  } split_t;

  typedef struct {
    logic [LW-1:0] limit;
    logic [VB-1:0] value;
    bit            fixed;
    split_t        result;
  } plan_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  logic [VB-1:0] value_to_split_i;
  logic          cfg_we_i;
  logic [LW-1:0] cfg_wdata_i;
  logic          done_o;
  logic [FW-1:0] first_factor_o;
  logic [VB-1:0] second_factor_o;
  logic          too_large_o;

  split_t        pending_splits[$];
  plan_row_t     plan[$];
  logic [LW-1:0] limit_now = fsplit_pkg::LIMIT_RESET;
  int unsigned   idle_pct = 17;
  bit            mismatch_seen = 1'b0;

  factor_split_two_dims_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .value_to_split_i(value_to_split_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .first_factor_o  (first_factor_o),
    .second_factor_o (second_factor_o),
    .too_large_o     (too_large_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #300ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic split_t predict_split(input logic [VB-1:0] val,
                                           input logic [LW-1:0] lim);
    longint unsigned primes[PRIME_SLOTS];
    longint unsigned rest;
    longint unsigned divisor;
    longint unsigned prod_a;
    longint unsigned prod_b;
    longint unsigned bound;
    int              count;
    int              k;
    split_t          res;
    rest    = 64'(val);
    divisor = 2;
    count   = 0;
    bound   = 64'(lim);
    if (rest >= 2) begin
      while (divisor * divisor <= rest && count + 1 < PRIME_SLOTS) begin
        if (rest % divisor == 0) begin
          primes[count] = divisor;
          count++;
          rest = rest / divisor;
        end else begin
          divisor = (divisor == 2) ? 3 : divisor + 2;
        end
      end
      if (rest > 1) begin
        primes[count] = rest;
        count++;
      end
    end
    prod_a = 1;
    prod_b = (val == 0) ? 0 : 1;
    k = count;
    while (k > 0 && primes[k-1] < bound && prod_a * primes[k-1] < bound) begin
      prod_a = prod_a * primes[k-1];
      k--;
    end
    while (k > 0) begin
      prod_b = (prod_b * primes[k-1]) & VALUE_MAX;
      k--;
    end
    res.too_large = (prod_a > fsplit_pkg::DIM_LIMIT) || (prod_b > fsplit_pkg::DIM_LIMIT);
    res.first     = (prod_a > fsplit_pkg::FIRST_MAX) ? fsplit_pkg::FIRST_MAX
                                                     : prod_a[FW-1:0];
    res.second    = prod_b[VB-1:0];
    return res;
  endfunction

  function automatic void add_row(input logic [LW-1:0] lim, input logic [VB-1:0] val,
                                  input bit fixed, input logic [FW-1:0] first,
                                  input logic [VB-1:0] second, input logic tl);
    plan_row_t row;
    row.limit            = lim;
    row.value            = val;
    row.fixed            = fixed;
    row.result.first     = first;
    row.result.second    = second;
    row.result.too_large = tl;
    plan.insert(plan.size(), row);
  endfunction

  task automatic issue_request(input logic [VB-1:0] val, input bit fixed,
                               input split_t given);
    start            <= 1'b1;
    value_to_split_i <= val;
    do @(posedge clk_i); while (busy);
    pending_splits.insert(pending_splits.size(),
                          fixed ? given : predict_split(val, limit_now));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic await_idle();
    start <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LW-1:0] lim);
    cfg_wdata_i <= lim;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_now = lim;
  endtask

  always @(posedge clk_i) begin
    split_t want;
    if (rst_ni && done_o) begin
      if (pending_splits.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_seen = 1'b1;
      end else begin
        want = pending_splits[0];
        pending_splits.delete(0);
        if (first_factor_o !== want.first) begin
          $error("first_factor: expected %0d, actual %0d", want.first, first_factor_o);
          mismatch_seen = 1'b1;
        end
        if (second_factor_o !== want.second) begin
          $error("second_factor: expected %0d, actual %0d", want.second, second_factor_o);
          mismatch_seen = 1'b1;
        end
        if (too_large_o !== want.too_large) begin
          $error("too_large: expected %0d, actual %0d", want.too_large, too_large_o);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    longint unsigned v;
    logic [LW-1:0] lim;
    int kind;
    start            <= 1'b0;
    value_to_split_i <= '0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    rst_ni           <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(15'd8192, 31'd1, 1'b1, 14'd1, 31'd1, 1'b0);
    add_row(15'd8192, 31'd0, 1'b1, 14'd1, 31'd0, 1'b0);
    add_row(15'd8192, 31'd12, 1'b1, 14'd12, 31'd1, 1'b0);
    add_row(15'd8192, 31'd8191, 1'b1, 14'd8191, 31'd1, 1'b0);
    add_row(15'd8192, 31'd8192, 1'b1, 14'd4096, 31'd2, 1'b0);
    add_row(15'd8192, 31'h7FFF_FFFE, 1'b0, '0, '0, 1'b0);
    add_row(15'd8192, 31'h4000_0000, 1'b1, 14'd4096, 31'd262144, 1'b1);
    add_row(15'd8192, 31'h7FFF_FFFF, 1'b1, 14'd1, 31'h7FFF_FFFF, 1'b1);
    add_row(15'd8192, 31'd15015, 1'b0, '0, '0, 1'b0);
    add_row(15'd0, 31'd6, 1'b1, 14'd1, 31'd6, 1'b0);
    add_row(15'd1, 31'd1, 1'b1, 14'd1, 31'd1, 1'b0);
    add_row(15'd2, 31'd2, 1'b1, 14'd1, 31'd2, 1'b0);
    add_row(15'd3, 31'd4, 1'b1, 14'd2, 31'd2, 1'b0);
    add_row(15'd32767, 31'd30000, 1'b1, 14'h3FFF, 31'd1, 1'b1);
    add_row(15'd32767, 31'd16385, 1'b1, 14'h3FFF, 31'd1, 1'b1);
    add_row(15'd32767, 31'd16384, 1'b1, 14'h3FFF, 31'd1, 1'b0);
    add_row(15'd16384, 31'd16383, 1'b1, 14'd16383, 31'd1, 1'b0);
    add_row(15'd100, 31'd8633, 1'b1, 14'd97, 31'd89, 1'b0);
    add_row(15'd100, 31'd606, 1'b1, 14'd1, 31'd606, 1'b0);
    add_row(15'd8192, 31'd196608, 1'b0, '0, '0, 1'b0);
    add_row(15'd8192, 31'd39601, 1'b0, '0, '0, 1'b0);

    foreach (plan[i]) begin
      if (plan[i].limit != limit_now) begin
        await_idle();
        write_limit(plan[i].limit);
      end
      issue_request(plan[i].value, plan[i].fixed, plan[i].result);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 80 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        await_idle();
        case ($urandom_range(0, 4))
          0: lim = LW'($urandom_range(0, 32767));
          1: lim = LW'($urandom_range(2, 400));
          2: lim = LW'($urandom_range(400, 16384));
          3: begin
            case ($urandom_range(0, 3))
              0: lim = fsplit_pkg::LIMIT_RESET;
              1: lim = 15'd32767;
              2: lim = 15'd16384;
              default: lim = LW'($urandom_range(0, 2));
            endcase
          end
          default: lim = LW'($urandom_range(16385, 32767));
        endcase
        write_limit(lim);
        repeat (25) begin
          kind = $urandom_range(0, 9);
          if (kind == 0) begin
            v = $urandom_range(0, 32'hF_FFFF);
          end else begin
            // keep most factors small so trial division stays short
            v = 1;
            repeat ($urandom_range(1, 8)) begin
              v = v * $urandom_range(2, 100);
              if (v > VALUE_MAX) v = v / 100;
            end
            if (kind < 4 && v * 40000 <= VALUE_MAX) v = v * $urandom_range(1, 40000);
            if (kind >= 8) begin
              while (v * 2 <= VALUE_MAX) v = v * 2;
            end else if (kind == 7) begin
              repeat ($urandom_range(0, 20)) if (v * 2 <= VALUE_MAX) v = v * 2;
            end
          end
          issue_request(v[VB-1:0], 1'b0, '0);
        end
      end
    end

    await_idle();
    repeat (200) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
